// ----- rtl/core/lfu_pkg.sv -----
// lfu_pkg: shared types and constants for the LFU cache table.
// Used by lfu_ctrl, lfu_datapath and the top level lfu_cache_table.
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int STAMP_W = 48;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;

    // Command codes carried on s_tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Register index (paddr[2]) of the capacity register
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    typedef logic signed [31:0] word_t;

    // controller to datapath
    typedef struct packed {
        logic             load;    // capture the input word, clear scan results
        logic             step;    // examine one slot at idx
        logic             commit;  // apply the update and load the result register
        logic [IDX_W-1:0] idx;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_room;  // result register is free or is being drained this cycle
    } dp_status_t;

endpackage

// ----- rtl/core/lfu_cache_table.sv -----
// lfu_cache_table: top level of the LFU key/value cache with recency tie break.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath; holds the APB capacity register.
//
// A fully associative store of 16 entries. Each input word is a get (look up a
// key, return its value, bump its use count and recency) or a put (update a
// present key the same way, or insert it with count 1, evicting the entry with
// the lowest use count, oldest first, once capacity entries are held). Every
// input word yields exactly one result word. An access takes the word, walks the
// entry table one slot a cycle (key match, victim and free-slot search share
// that single read port), then, once the result register has room, writes the
// table and loads the result register; s_tready rises again the cycle after
// that. The result register lets the next word be taken while a result still
// waits on m_tready. Capacity (register 0, byte address 0) clamps at 16; zero
// turns every put into a no-op. Write capacity only while no access is in flight.
module lfu_cache_table
    import lfu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] cmd (0 get, 1 put)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]  m_tuser,   // [0] hit, [1] evicted
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0] capacity_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic             out_hit, out_evicted;
    word_t            out_read_value, out_evicted_key;

    // capacity register: written on the APB access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity_reg} : '0;

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lfu_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .capacity        (capacity_reg),
        .in_cmd          (s_tuser[0]),
        .in_key          (s_tdata[31:0]),
        .in_value        (s_tdata[63:32]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_hit         (out_hit),
        .out_read_value  (out_read_value),
        .out_evicted     (out_evicted),
        .out_evicted_key (out_evicted_key)
    );

    assign m_tdata = {out_evicted_key, out_read_value};
    assign m_tuser = {out_evicted, out_hit};

endmodule

// ----- rtl/core/lfu_ctrl.sv -----
// lfu_ctrl: sequencer for one cache access (accept, slot scan, commit).
// Depends on lfu_pkg; drives lfu_datapath through ctrl_cmd_t.
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (idx_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                // hold until the result register can take the word
                if (status.out_room) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- rtl/core/lfu_datapath.sv -----
// lfu_datapath: entry table, scan result registers, update logic and result register.
// Depends on lfu_pkg; sequenced by lfu_ctrl.
module lfu_datapath
    import lfu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  logic [CAP_W-1:0] capacity,
    input  logic             in_cmd,
    input  word_t            in_key,
    input  word_t            in_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_hit,
    output word_t            out_read_value,
    output logic             out_evicted,
    output word_t            out_evicted_key
);

    // entry table
    logic                 valid_reg [ENTRIES];
    word_t                key_mem   [ENTRIES];
    word_t                val_mem   [ENTRIES];
    logic [CNT_W-1:0]     cnt_mem   [ENTRIES];
    logic [STAMP_W-1:0]   rec_mem   [ENTRIES];

    logic [STAMP_W-1:0]   clock_reg;
    logic [OCC_W-1:0]     occ_reg;

    // captured request
    logic                 cmd_reg;
    word_t                key_reg;
    word_t                value_reg;

    // scan results
    logic                 found_reg;
    logic [IDX_W-1:0]     found_idx_reg;
    word_t                found_val_reg;
    logic [CNT_W-1:0]     found_cnt_reg;
    logic                 best_vld_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [CNT_W-1:0]     best_cnt_reg;
    logic [STAMP_W-1:0]   best_rec_reg;
    word_t                best_key_reg;
    logic                 free_vld_reg;
    logic [IDX_W-1:0]     free_idx_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    word_t                out_rd_reg;
    logic                 out_ev_reg;
    word_t                out_evk_reg;

    // slot under scan
    logic                 rd_valid;
    word_t                rd_key;
    logic                 take_match, take_best, take_free;

    // commit decision
    logic [OCC_W-1:0]     cap_eff;
    logic                 do_touch, do_wr_value, do_insert, use_victim, from_free;
    logic [IDX_W-1:0]     tgt_idx;
    logic                 res_hit, res_ev;
    word_t                res_rd, res_evk;
    logic [CNT_W-1:0]     touched_cnt;

    assign rd_valid = valid_reg[cmd.idx];
    assign rd_key   = key_mem[cmd.idx];

    assign take_match = rd_valid && !found_reg && (rd_key == key_reg);
    assign take_best  = rd_valid && (!best_vld_reg ||
                        (cnt_mem[cmd.idx] < best_cnt_reg) ||
                        ((cnt_mem[cmd.idx] == best_cnt_reg) &&
                         (rec_mem[cmd.idx] < best_rec_reg)));
    assign take_free  = !rd_valid && !free_vld_reg;

    assign cap_eff = (int'(capacity) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(capacity);
    assign touched_cnt = (found_cnt_reg == '1) ? found_cnt_reg : found_cnt_reg + 1'b1;

    always_comb begin
        do_touch    = 1'b0;
        do_wr_value = 1'b0;
        do_insert   = 1'b0;
        use_victim  = 1'b0;
        from_free   = 1'b0;
        tgt_idx     = found_idx_reg;
        res_hit     = 1'b0;
        res_rd      = '1;
        res_ev      = 1'b0;
        res_evk     = '0;
        if (cmd_reg == CMD_GET) begin
            if (found_reg) begin
                res_hit  = 1'b1;
                res_rd   = found_val_reg;
                do_touch = 1'b1;
            end
        end else if (cap_eff != '0) begin
            if (found_reg) begin
                res_hit     = 1'b1;
                do_touch    = 1'b1;
                do_wr_value = 1'b1;
            end else begin
                // full (or no free slot): replace the least used, oldest entry
                use_victim = (occ_reg >= cap_eff) || !free_vld_reg;
                if (use_victim) begin
                    tgt_idx   = best_idx_reg;
                    do_insert = best_vld_reg;
                    res_ev    = best_vld_reg;
                    res_evk   = best_vld_reg ? best_key_reg : '0;
                end else begin
                    tgt_idx   = free_idx_reg;
                    do_insert = 1'b1;
                    from_free = 1'b1;
                end
            end
        end
    end

    // request capture and scan
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_cmd;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        if (cmd.step && take_match) begin
            found_idx_reg <= cmd.idx;
            found_val_reg <= val_mem[cmd.idx];
            found_cnt_reg <= cnt_mem[cmd.idx];
        end
        if (cmd.step && take_best) begin
            best_idx_reg <= cmd.idx;
            best_cnt_reg <= cnt_mem[cmd.idx];
            best_rec_reg <= rec_mem[cmd.idx];
            best_key_reg <= rd_key;
        end
        if (cmd.step && take_free) begin
            free_idx_reg <= cmd.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            free_vld_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            free_vld_reg <= 1'b0;
        end else if (cmd.step) begin
            found_reg    <= found_reg | take_match;
            best_vld_reg <= best_vld_reg | take_best;
            free_vld_reg <= free_vld_reg | take_free;
        end
    end

    // table update
    always_ff @(posedge aclk) begin
        if (cmd.commit && do_touch) begin
            cnt_mem[tgt_idx] <= touched_cnt;
            rec_mem[tgt_idx] <= clock_reg;
        end
        if (cmd.commit && do_wr_value) begin
            val_mem[tgt_idx] <= value_reg;
        end
        if (cmd.commit && do_insert) begin
            key_mem[tgt_idx] <= key_reg;
            val_mem[tgt_idx] <= value_reg;
            cnt_mem[tgt_idx] <= CNT_W'(1);
            rec_mem[tgt_idx] <= clock_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
            clock_reg <= '0;
            occ_reg   <= '0;
        end else if (cmd.commit) begin
            if (do_insert) begin
                valid_reg[tgt_idx] <= 1'b1;
            end
            if (do_touch || do_insert) begin
                clock_reg <= clock_reg + 1'b1;
            end
            if (do_insert && from_free) begin
                occ_reg <= occ_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg <= res_hit;
            out_rd_reg  <= res_rd;
            out_ev_reg  <= res_ev;
            out_evk_reg <= res_evk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_room = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_read_value  = out_rd_reg;
    assign out_evicted     = out_ev_reg;
    assign out_evicted_key = out_evk_reg;

endmodule

// ----- rtl/core/lfu_checker.sv -----
// lfu_checker: port-level assertions for lfu_cache_table.
// Depends on nothing but the top level's ports; attached by the bind below.
module lfu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one access at a time: input closes right after a word is taken
    a_in_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during an access");

    // a miss or a put reads back all ones
    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'hFFFF_FFFF)
        else $error("read_value not all ones without a hit");

    // evicted key is zero unless something was evicted
    a_evk_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[63:32] == 32'h0)
        else $error("evicted_key set without an eviction");

    // an eviction only comes from an insert, never with a hit
    a_ev_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("eviction reported together with a hit");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for lfu_cache_table, driven through its stream and APB ports.
// Depends on lfu_pkg and the lfu_cache_table RTL; predicts every result word in-line.
module tb_top
    import lfu_pkg::*;
();

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 4;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 62;
    localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to back up the input
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_MAX     = 24;

    localparam word_t KEY_MAX = 32'sh7FFF_FFFF;
    localparam word_t KEY_MIN = 32'sh8000_0000;

    // One result word, field by field.
    typedef struct packed {
        logic  hit;
        word_t read_value;
        logic  evicted;
        word_t evicted_key;
    } access_res_t;

    typedef enum logic {ROW_ACCESS, ROW_SET_CAP} row_kind_t;

    // Directed stimulus row; has_res marks rows whose result is typed in by hand.
    typedef struct packed {
        row_kind_t   kind;
        logic        cmd;
        word_t       key;
        word_t       value;   // capacity for ROW_SET_CAP rows
        logic        has_res;
        access_res_t res;
    } dir_row_t;

    localparam access_res_t RES_MISS    = '{1'b0, -1, 1'b0, 0};
    localparam access_res_t RES_UPDATED = '{1'b1, -1, 1'b0, 0};

    // Walk from an empty table through updates, evictions, a capacity below the
    // occupancy, the disabled store and a clamped capacity.
    localparam dir_row_t DIRECTED_ROWS [32] = '{
        '{ROW_ACCESS,  CMD_GET, 0,       0,       1'b1, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, KEY_MAX, KEY_MIN, 1'b1, RES_MISS},
        '{ROW_ACCESS,  CMD_GET, KEY_MAX, -1,      1'b1, '{1'b1, KEY_MIN, 1'b0, 0}},
        '{ROW_ACCESS,  CMD_PUT, KEY_MIN, KEY_MAX, 1'b1, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, KEY_MAX, 0,       1'b1, RES_UPDATED},
        '{ROW_ACCESS,  CMD_GET, KEY_MIN, 0,       1'b1, '{1'b1, KEY_MAX, 1'b0, 0}},
        '{ROW_ACCESS,  CMD_GET, -1,      -1,      1'b1, RES_MISS},
        // full at two entries: the lower use count goes first
        '{ROW_SET_CAP, CMD_GET, 0,       2,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 5,       5,       1'b1, '{1'b0, -1, 1'b1, KEY_MIN}},
        '{ROW_ACCESS,  CMD_PUT, 6,       6,       1'b1, '{1'b0, -1, 1'b1, 5}},
        '{ROW_ACCESS,  CMD_GET, 5,       0,       1'b1, RES_MISS},
        // capacity below occupancy: one victim, its slot reused
        '{ROW_SET_CAP, CMD_GET, 0,       1,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 7,       7,       1'b1, '{1'b0, -1, 1'b1, 6}},
        '{ROW_ACCESS,  CMD_GET, KEY_MAX, 0,       1'b1, '{1'b1, 0, 1'b0, 0}},
        // disabled store: puts do nothing, even on a present key
        '{ROW_SET_CAP, CMD_GET, 0,       0,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, KEY_MAX, 9,       1'b1, RES_MISS},
        '{ROW_ACCESS,  CMD_GET, KEY_MAX, 0,       1'b1, '{1'b1, 0, 1'b0, 0}},
        '{ROW_ACCESS,  CMD_PUT, 8,       8,       1'b1, RES_MISS},
        // oversized capacity clamps to the table size
        '{ROW_SET_CAP, CMD_GET, 0,       31,      1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 8,       8,       1'b1, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 100,     32'sh5A5A_A5A5, 1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 101,     32'shA5A5_5A5A, 1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 102,     1,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 103,     2,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 104,     3,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 105,     4,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_GET, 7,       0,       1'b1, '{1'b1, 7, 1'b0, 0}},
        // shrink well below occupancy, then insert and update
        '{ROW_SET_CAP, CMD_GET, 0,       3,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 200,     1,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 201,     2,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_GET, 200,     0,       1'b0, RES_MISS},
        '{ROW_ACCESS,  CMD_PUT, 201,     3,       1'b0, RES_MISS}
    };

    localparam logic [CAP_W-1:0] CAP_PLAN [6] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] key, [63:32] value
    logic [0:0]  s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] read_value, [63:32] evicted_key
    logic [1:0]  m_tuser;   // [0] hit, [1] evicted
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the table, kept in step with every accepted word.
    logic               slot_live  [ENTRIES];
    word_t              slot_key   [ENTRIES];
    word_t              slot_data  [ENTRIES];
    logic [CNT_W-1:0]   slot_uses  [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [ENTRIES];
    logic [STAMP_W-1:0] tick;
    int unsigned        live_count;
    logic [CAP_W-1:0]   cap_reg;

    access_res_t awaited_results [$];
    int          mismatches = 0;

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    lfu_cache_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // Apply one access to the shadow table and return the result word it owes.
    function automatic access_res_t predict_access(logic cmd, word_t key, word_t value);
        access_res_t r;
        int unsigned limit;
        int          found;
        int          slot;
        r     = RES_MISS;
        limit = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
        found = -1;
        slot  = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == key)
                found = i;
        // a disabled store ignores puts entirely
        if (cmd == CMD_PUT && limit == 0)
            return r;
        if (found >= 0) begin
            r.hit = 1'b1;
            if (cmd == CMD_GET)
                r.read_value = slot_data[found];
            else
                slot_data[found] = value;
            if (slot_uses[found] != '1)
                slot_uses[found] = slot_uses[found] + 1'b1;
            slot_stamp[found] = tick;
            tick = tick + 1'b1;
        end else if (cmd == CMD_PUT) begin
            if (live_count >= limit) begin
                // lowest use count, then oldest stamp, then lowest index
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_live[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                        (slot_uses[i] == slot_uses[slot] && slot_stamp[i] < slot_stamp[slot])))
                        slot = i;
                r.evicted     = 1'b1;
                r.evicted_key = slot_key[slot];
            end else begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !slot_live[i])
                        slot = i;
                live_count++;
            end
            slot_live[slot]  = 1'b1;
            slot_key[slot]   = key;
            slot_data[slot]  = value;
            slot_uses[slot]  = 1;
            slot_stamp[slot] = tick;
            tick = tick + 1'b1;
        end
        return r;
    endfunction

    function automatic int tx_gap();
        return (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    endfunction

    // Offer one word after an optional gap; called and returns at a rising edge.
    // Hold tvalid high between back-to-back words.
    task automatic offer_word(input logic cmd, input word_t key, input word_t value,
                              input int gap, input logic has_res, input access_res_t res);
        access_res_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_access(cmd, key, value);
        awaited_results.push_back(has_res ? res : predicted);
    endtask

    // Drop tvalid and wait until every result word owed has been taken.
    task automatic go_quiet();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    task automatic read_capacity(input logic [CAP_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(want))
            note_mismatch("capacity readback", 64'(want), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write capacity once the block is idle; upper data bits carry noise.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [31:0] wdata;
        wdata = $urandom();
        wdata[CAP_W-1:0] = cap;
        go_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cap_reg = cap;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        read_capacity(cap);
    endtask

    // Result checker: compare every taken result word with the oldest prediction.
    always @(posedge aclk) begin : result_check
        access_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("unexpected result word", 64'd0, m_tdata);
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser[0] !== want.hit)
                    note_mismatch("hit", 64'(want.hit), 64'(m_tuser[0]));
                if (m_tdata[31:0] !== want.read_value)
                    note_mismatch("read_value", 64'(want.read_value), 64'(m_tdata[31:0]));
                if (m_tuser[1] !== want.evicted)
                    note_mismatch("evicted", 64'(want.evicted), 64'(m_tuser[1]));
                if (m_tdata[63:32] !== want.evicted_key)
                    note_mismatch("evicted_key", 64'(want.evicted_key), 64'(m_tdata[63:32]));
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request that backs
    // the block up until it stops taking input words.
    initial begin : result_sink
        int hold;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                hold = LONG_HOLD;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 17);
            end else begin
                m_tready <= 1'b1;
                hold = $urandom_range(1, 8);
            end
            repeat (hold) @(posedge aclk);
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        dir_row_t         row;
        word_t            key_pool [POOL_MAX];
        int unsigned      pool_size;
        logic [CAP_W-1:0] cap;
        logic             cmd;
        word_t            key;
        bit               calm;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        for (int i = 0; i < ENTRIES; i++)
            slot_live[i] = 1'b0;
        tick       = '0;
        live_count = 0;
        cap_reg    = CAPACITY_RESET;
        foreach (key_pool[i])
            key_pool[i] = $urandom();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_capacity(CAPACITY_RESET);

        // directed part
        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_SET_CAP)
                set_capacity(row.value[CAP_W-1:0]);
            else
                offer_word(row.cmd, row.key, row.value, tx_gap(), row.has_res, row.res);
        end

        // random phases: a capacity each, keys drawn mostly from a small pool so
        // that hits, updates and evictions dominate; the last phases run flat out
        for (int p = 0; p < PHASES; p++) begin
            calm       = (p >= PHASES - 2);
            tx_idle_on = !calm && $urandom_range(0, 3) != 0;
            rx_idle_on = !calm && $urandom_range(0, 3) != 0;
            if (p < 6)
                cap = CAP_PLAN[p];
            else
                cap = ($urandom_range(0, 7) == 0) ? '0 : CAP_W'($urandom_range(1, 20));
            set_capacity(cap);

            // carry a few keys over so old entries still get hit
            pool_size = ((cap > ENTRIES) ? ENTRIES : cap) + $urandom_range(1, 6);
            for (int i = 4; i < POOL_MAX; i++)
                key_pool[i] = $urandom();

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 4 && n == 10)
                    rx_hold_req = 1'b1;
                if (p == 5 && n == 20)
                    go_quiet();
                cmd = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 6) != 0)
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    key = $urandom();
                offer_word(cmd, key, $urandom(), tx_gap(), 1'b0, RES_MISS);
            end
        end

        go_quiet();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
